// File: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Entry layout, request and response payloads, operation codes and the
// control bundle broadcast from the top level to every queue cell.
// ----------------------------------------------------------------------------
package spq_pkg;

   // number of queue cells
   localparam int QUEUE_DEPTH = 16;
   // width of the entry count, able to hold QUEUE_DEPTH itself
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // operation codes; the fourth code acts as a peek
   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2
   } op_type;

   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] amount;
      logic [15:0] tag;
   } entry_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  priority_req;
      logic [15:0] amount;
      logic [15:0] tag;
   } req_type;

   typedef struct packed {
      logic [15:0] head_tag;
      logic        is_empty;
      logic [4:0]  fill_count;
      logic        push_refused;
   } rsp_type;

   // broadcast to all cells for one request
   typedef struct packed {
      logic      push_en;
      logic      pop_en;
      entry_type new_entry;
   } ctl_type;

endpackage

// File: src/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept in sorted order
//
// A request is taken at a rising edge with start high and busy low. busy is
// always low: the queue takes one request every cycle. Each request is a
// push, a pop or a peek; a fourth code acts as a peek. Entries are ordered by
// priority, then amount, highest first; equal entries leave in arrival order.
// Every request gives one response on rsp_data, marked by rsp_valid for one
// cycle, in the cycle after the request was taken. The response shows
// the head tag (0 when empty), the empty flag, the count and whether a push
// was refused because the queue was full.
// The queue is a row of QUEUE_DEPTH cells; all cells at once compare their
// entries with the pushed one and each loads its own, its neighbor's or the
// new entry, whatever the fill level.
// Reset empties the queue (count to zero) and clears the response strobe;
// cell contents are not cleared. The receiver cannot stall responses.
// ----------------------------------------------------------------------------
module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   rsp_valid_ff;
   logic                   refused_ff;
   logic                   refused_in;
   logic                   accept;
   logic                   is_full;
   logic                   is_void;
   ctl_type                ctl;
   logic [QUEUE_DEPTH-1:0] occupied;
   logic [QUEUE_DEPTH-1:0] goes;
   entry_type              entries [QUEUE_DEPTH];

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign is_full = count_ff == CNT_W'(QUEUE_DEPTH);
   assign is_void = count_ff == '0;

   // decode the request into the cell broadcast and the next count
   always_comb begin
      ctl.push_en   = 1'b0;
      ctl.pop_en    = 1'b0;
      ctl.new_entry = '{prio: req_data.priority_req, amount: req_data.amount,
                        tag: req_data.tag};
      count_in      = count_ff;
      refused_in    = 1'b0;
      if (accept) begin
         case (req_data.op)
            OP_PUSH: begin
               if (is_full) begin
                  refused_in = 1'b1;
               end else begin
                  ctl.push_en = 1'b1;
                  count_in    = count_ff + 1'b1;
               end
            end
            OP_POP: begin
               if (!is_void) begin
                  ctl.pop_en = 1'b1;
                  count_in   = count_ff - 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // row of cells
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      assign occupied[i] = CNT_W'(i) < count_ff;
      spq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (occupied[i]),
         .prev_goes  ((i == 0) ? 1'b0 : goes[(i == 0) ? 0 : i - 1]),
         .prev_entry ((i == 0) ? ctl.new_entry : entries[(i == 0) ? 0 : i - 1]),
         .next_entry ((i == QUEUE_DEPTH - 1) ? entries[i]
                      : entries[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
         .goes       (goes[i]),
         .entry      (entries[i])
      );
   end

   // hold count and response flags
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         refused_ff   <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
         refused_ff   <= refused_in;
      end
   end

   // build the response from the updated state
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_data.head_tag      = is_void ? 16'd0 : entries[0].tag;
   assign rsp_data.is_empty      = is_void;
   assign rsp_data.fill_count    = 5'(count_ff);
   assign rsp_data.push_refused  = refused_ff;

   // count stays within the queue depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   // a refused push only when the queue was full and stays full
   a_refused_full: assert property (@(posedge clock) disable iff (reset)
      refused_in |=> (refused_ff && is_full))
      else $error("push refused on a queue with room");

   // a response follows every request in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("response missing after request");

   // a successful push grows the count by one
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.push_en |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not grow the count");

   // cell insert flags are ordered: once the new entry fits, all later do too
   a_goes_monotonic: assert property (@(posedge clock) disable iff (reset)
      ctl.push_en |-> ($countones(goes ^ (goes << 1)) <= 1))
      else $error("insert position not unique");

endmodule

// File: src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one position of the sorted queue
// Holds one entry, compares it against the entry being pushed and takes the
// new entry, its upper or its lower neighbor's entry, or keeps its own.
// ----------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
(
   input  logic      clock,
   input  ctl_type   ctl,
   input  logic      occupied,
   input  logic      prev_goes,
   input  entry_type prev_entry,
   input  entry_type next_entry,
   output logic      goes,
   output entry_type entry
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      below;

   // new entry is served before this one: strictly higher keys only,
   // so equal entries stay ahead (arrival order)
   always_comb begin
      if (entry_ff.prio != ctl.new_entry.prio) begin
         below = entry_ff.prio < ctl.new_entry.prio;
      end else begin
         below = entry_ff.amount < ctl.new_entry.amount;
      end
   end

   // new entry lands at or above this position
   assign goes = !occupied || below;

   // select insert, shift down on push, shift up on pop, or hold
   always_comb begin
      entry_in = entry_ff;
      if (ctl.push_en) begin
         if (goes && !prev_goes) begin
            entry_in = ctl.new_entry;
         end else if (goes) begin
            entry_in = prev_entry;
         end
      end else if (ctl.pop_en) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sorted priority queue
// Drives push, pop and peek requests in random bursts and predicts every
// response with a sorted-list model of the queue. A directed opening covers
// the empty and full cases, the key extremes, equal-key ordering and the
// unused operation code; random traffic then sweeps the queue between empty
// and full many times.
// ----------------------------------------------------------------------------

// Sorted-list model of the queue and the responses it still owes
class priority_queue_tracker;
   spq_pkg::entry_type held [spq_pkg::QUEUE_DEPTH];
   int unsigned        occupied;
   spq_pkg::rsp_type   pending_status [$];
   int unsigned        failures;

   function new();
      occupied = 0;
      failures = 0;
   endfunction

   // Apply one accepted request to the model and queue its response
   function void note_request(spq_pkg::req_type r);
      int unsigned      pos;
      int               i;
      logic             refused;
      spq_pkg::rsp_type status;
      refused = 1'b0;
      if (r.op == spq_pkg::OP_PUSH) begin
         if (occupied >= spq_pkg::QUEUE_DEPTH) begin
            refused = 1'b1;
         end else begin
            // skip entries that rank at or above the new one, so ties stay FIFO
            pos = 0;
            while (pos < occupied &&
                   (held[pos].prio > r.priority_req ||
                    (held[pos].prio == r.priority_req &&
                     held[pos].amount >= r.amount)))
               pos++;
            for (i = occupied; i > pos; i--)
               held[i] = held[i-1];
            held[pos].prio   = r.priority_req;
            held[pos].amount = r.amount;
            held[pos].tag    = r.tag;
            occupied++;
         end
      end else if (r.op == spq_pkg::OP_POP && occupied > 0) begin
         // advance every entry one place toward the head
         for (i = 1; i < occupied; i++)
            held[i-1] = held[i];
         occupied--;
      end
      status.head_tag     = (occupied > 0) ? held[0].tag : 16'h0000;
      status.is_empty     = (occupied == 0);
      status.fill_count   = 5'(occupied);
      status.push_refused = refused;
      pending_status.push_back(status);
   endfunction

   // Compare one response with the oldest prediction
   function void check_response(spq_pkg::rsp_type got);
      spq_pkg::rsp_type want;
      if (pending_status.size() == 0) begin
         $error("response with no request pending: head_tag %0h fill_count %0d",
                got.head_tag, got.fill_count);
         failures++;
         return;
      end
      want = pending_status.pop_front();
      if (got.head_tag !== want.head_tag) begin
         $error("head_tag mismatch: expected %0h, actual %0h",
                want.head_tag, got.head_tag);
         failures++;
      end
      if (got.is_empty !== want.is_empty) begin
         $error("is_empty mismatch: expected %0b, actual %0b",
                want.is_empty, got.is_empty);
         failures++;
      end
      if (got.fill_count !== want.fill_count) begin
         $error("fill_count mismatch: expected %0d, actual %0d",
                want.fill_count, got.fill_count);
         failures++;
      end
      if (got.push_refused !== want.push_refused) begin
         $error("push_refused mismatch: expected %0b, actual %0b",
                want.push_refused, got.push_refused);
         failures++;
      end
   endfunction
endclass

module tb_top;
   import spq_pkg::*;

   // op code without a defined meaning; the queue treats it as a peek
   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int unsigned RANDOM_ITEMS = 1200;
   localparam int unsigned CYCLE_LIMIT  = 60000;

   typedef enum int {FILL_HEAVY, DRAIN_HEAVY, BALANCED} traffic_mix_type;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   priority_queue_tracker tracker;
   int unsigned           cycle_count;

   sorted_priority_queue dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Sample both channels at the rising edge and bound the run length
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (rsp_valid)
            tracker.check_response(rsp_data);
         if (start && !busy)
            tracker.note_request(req_data);
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Present one request and hold it until the queue takes it
   task automatic send_request(input req_type r);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and put fresh noise on the request bus in each idle cycle; n sets the gap
   task automatic hold_idle(input int unsigned n);
      logic [63:0] noise;
      repeat (n) begin
         noise    = {$urandom(), $urandom()};
         @(negedge clock);
         start    <= 1'b0;
         req_data <= noise[$bits(req_type)-1:0];
      end
   endtask

   function automatic req_type make_request(input logic [1:0] op, input logic [7:0] prio,
                                            input logic [15:0] amount,
                                            input logic [15:0] tag);
      req_type r;
      r.op           = op;
      r.priority_req = prio;
      r.amount       = amount;
      r.tag          = tag;
      return r;
   endfunction

   initial begin
      req_type         r;
      traffic_mix_type mix;
      int unsigned     sent;
      int unsigned     burst;
      int unsigned     pick;
      int unsigned     push_share;
      int              i;

      tracker     = new();
      cycle_count = 0;
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty queue: peek, pop and the unused code change nothing
      send_request(make_request(OP_PEEK, 8'hFF, 16'hFFFF, 16'hFFFF));
      send_request(make_request(OP_POP, 8'h00, 16'h0000, 16'h0000));
      send_request(make_request(OP_UNUSED, 8'hA5, 16'h5A5A, 16'hC3C3));

      // key extremes, a zero tag and an exact tie on both keys
      send_request(make_request(OP_PUSH, 8'h00, 16'h0000, 16'h0000));
      send_request(make_request(OP_PUSH, 8'hFF, 16'hFFFF, 16'hFFFF));
      send_request(make_request(OP_PUSH, 8'hFF, 16'hFFFF, 16'h1234));
      send_request(make_request(OP_PUSH, 8'hFF, 16'h0000, 16'h00FF));
      send_request(make_request(OP_PUSH, 8'h00, 16'hFFFF, 16'hFF00));
      send_request(make_request(OP_PUSH, 8'h80, 16'h8000, 16'h8001));

      // fill to capacity with equal keys, so arrival order decides
      for (i = 0; i < QUEUE_DEPTH - 6; i++)
         send_request(make_request(OP_PUSH, 8'h80, 16'h8000, 16'(16'h0100 + i)));

      // full queue: refused push, peek, unused code, then pop and refill
      send_request(make_request(OP_PUSH, 8'hFF, 16'hFFFF, 16'hBEEF));
      send_request(make_request(OP_PEEK, 8'h00, 16'h0000, 16'h0000));
      send_request(make_request(OP_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF));
      send_request(make_request(OP_POP, 8'hFF, 16'hFFFF, 16'hFFFF));
      send_request(make_request(OP_PUSH, 8'h00, 16'h0000, 16'h7777));
      send_request(make_request(OP_POP, 8'h5A, 16'hA5A5, 16'h3C3C));

      // random bursts; each burst leans toward filling, draining or neither
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst      = $urandom_range(1, 24);
         mix        = traffic_mix_type'($urandom_range(0, 2));
         push_share = (mix == FILL_HEAVY) ? 70 : (mix == DRAIN_HEAVY) ? 25 : 45;
         for (i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
            r.priority_req = 8'($urandom());
            r.amount       = 16'($urandom());
            r.tag          = 16'($urandom());
            pick           = $urandom_range(0, 99);
            if (pick < push_share) begin
               r.op = OP_PUSH;
               // crowd the keys into a few values so ties are common
               case ($urandom_range(0, 3))
                  0: r.priority_req = 8'($urandom_range(0, 3));
                  1: r.priority_req = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                  default: ;
               endcase
               case ($urandom_range(0, 3))
                  0: r.amount = 16'($urandom_range(0, 3));
                  1: r.amount = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                  default: ;
               endcase
            end else if (pick < 85) begin
               r.op = OP_POP;
            end else if (pick < 96) begin
               r.op = OP_PEEK;
            end else begin
               r.op = OP_UNUSED;
            end
            send_request(r);
            sent++;
         end
         // leave some bursts back to back, others separated by a gap
         if ($urandom_range(0, 3) != 0)
            hold_idle($urandom_range(1, 6));
      end
      hold_idle(1);

      // drain outstanding responses, then idle before finishing
      while (tracker.pending_status.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      if (tracker.failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
